[rtl/atmw_pkg.sv]
// Shared constants and types for the alpha-trimmed mean window filter.
package atmw_pkg;

  localparam int DEF_WINDOW_PIXELS = 9;
  localparam int DEF_PIXEL_BITS    = 8;
  localparam int MAX_WINDOW        = 9;
  localparam int COUNT_BITS        = 4;
  localparam int TRIM_BITS         = 4;
  localparam int OUT_BITS          = 16;
  localparam int FRAC_BITS         = 8;

  localparam logic [TRIM_BITS-1:0] TRIM_RESET = TRIM_BITS'(1);

  // Sideband that travels with each word through the front stages
  typedef struct packed {
    logic                  pass;
    logic [COUNT_BITS-1:0] kept;
  } side_t;

endpackage

[rtl/alpha_trimmed_mean_window.sv]
// Alpha-trimmed mean of one clipped pixel window, five-stage pipeline.
// Throughput: one word per clock; busy is low whenever rst is low.
// Stages: clip and trim check, rank compare, kept-pixel sum, reciprocal multiply, scale/saturate.
// Reset (rst, synchronous): clears all stage valid bits and sets trim_count to 1.
// The result side cannot stall; every accepted word yields exactly one done pulse.
module alpha_trimmed_mean_window #(
  parameter int WINDOW_PIXELS = atmw_pkg::DEF_WINDOW_PIXELS,
  parameter int PIXEL_BITS    = atmw_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [PIXEL_BITS-1:0]           pixel_0,
  input  logic [PIXEL_BITS-1:0]           pixel_1,
  input  logic [PIXEL_BITS-1:0]           pixel_2,
  input  logic [PIXEL_BITS-1:0]           pixel_3,
  input  logic [PIXEL_BITS-1:0]           pixel_4,
  input  logic [PIXEL_BITS-1:0]           pixel_5,
  input  logic [PIXEL_BITS-1:0]           pixel_6,
  input  logic [PIXEL_BITS-1:0]           pixel_7,
  input  logic [PIXEL_BITS-1:0]           pixel_8,
  input  logic [atmw_pkg::COUNT_BITS-1:0] valid_count,
  input  logic [PIXEL_BITS-1:0]           center_pixel,
  input  logic                            cfg_we,
  input  logic [atmw_pkg::TRIM_BITS-1:0]  cfg_wdata,
  output logic                            done,
  output logic [atmw_pkg::OUT_BITS-1:0]   filtered_value,
  output logic                            passed_through
);
  import atmw_pkg::*;

  localparam int SUM_BITS   = PIXEL_BITS + 4;
  localparam int SHIFT      = SUM_BITS + FRAC_BITS + 4;
  localparam int RECIP_BITS = SHIFT + 1;
  localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam int QUO_BITS   = SUM_BITS + FRAC_BITS;
  localparam int EXT_BITS   = QUO_BITS + OUT_BITS;

  localparam logic [COUNT_BITS-1:0] W_CNT = COUNT_BITS'(WINDOW_PIXELS);
  localparam logic [RECIP_BITS-1:0] ONE   = RECIP_BITS'(1) << SHIFT;

  // Rounded-up reciprocals of the kept count; exact floor for sums this narrow
  localparam logic [RECIP_BITS-1:0] RECIP_TAB [16] = '{
    '0,
    RECIP_BITS'(ONE),
    RECIP_BITS'((ONE + 1) / 2),
    RECIP_BITS'((ONE + 2) / 3),
    RECIP_BITS'((ONE + 3) / 4),
    RECIP_BITS'((ONE + 4) / 5),
    RECIP_BITS'((ONE + 5) / 6),
    RECIP_BITS'((ONE + 6) / 7),
    RECIP_BITS'((ONE + 7) / 8),
    RECIP_BITS'((ONE + 8) / 9),
    '0, '0, '0, '0, '0, '0
  };

  logic [TRIM_BITS-1:0] trim_count;

  logic [PIXEL_BITS-1:0] pix_in [MAX_WINDOW];
  logic [COUNT_BITS-1:0] n_clip;
  logic [TRIM_BITS:0]    trim2;
  side_t                 side_next;
  logic [COUNT_BITS-1:0] hi_next;

  logic                  v1;
  logic [PIXEL_BITS-1:0] pix1 [WINDOW_PIXELS];
  logic [COUNT_BITS-1:0] n1;
  logic [TRIM_BITS-1:0]  t1;
  logic [COUNT_BITS-1:0] hi1;
  side_t                 side1;
  logic [PIXEL_BITS-1:0] cen1;

  logic [COUNT_BITS-1:0]    rank [WINDOW_PIXELS];
  logic [WINDOW_PIXELS-1:0] keep_next;

  logic                     v2;
  logic [WINDOW_PIXELS-1:0] keep2;
  logic [PIXEL_BITS-1:0]    pix2 [WINDOW_PIXELS];
  side_t                    side2;
  logic [PIXEL_BITS-1:0]    cen2;

  logic [SUM_BITS-1:0]   sum_next;
  logic                  v3;
  logic [SUM_BITS-1:0]   sum3;
  side_t                 side3;
  logic [PIXEL_BITS-1:0] cen3;

  logic                  v4;
  logic [PROD_BITS-1:0]  prod4;
  logic                  pass4;
  logic [PIXEL_BITS-1:0] cen4;

  logic [EXT_BITS-1:0]   sel_ext;
  logic [OUT_BITS-1:0]   value_next;

  // Only reset holds off new words
  assign busy = rst;

  // Trim register
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_count <= TRIM_RESET;
    end else if (cfg_we) begin
      trim_count <= cfg_wdata;
    end
  end

  // Gather pixel slots
  always_comb begin
    pix_in[0] = pixel_0;
    pix_in[1] = pixel_1;
    pix_in[2] = pixel_2;
    pix_in[3] = pixel_3;
    pix_in[4] = pixel_4;
    pix_in[5] = pixel_5;
    pix_in[6] = pixel_6;
    pix_in[7] = pixel_7;
    pix_in[8] = pixel_8;
  end

  // Stage 1: clip count, decide pass-through, work out kept count and window bounds
  always_comb begin
    n_clip         = (valid_count > W_CNT) ? W_CNT : valid_count;
    trim2          = {trim_count, 1'b0};
    side_next.pass = ({1'b0, n_clip} <= trim2);
    side_next.kept = n_clip - trim2[COUNT_BITS-1:0];
    hi_next        = n_clip - COUNT_BITS'(trim_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      pix1[i] <= pix_in[i];
    end
    n1    <= n_clip;
    t1    <= trim_count;
    hi1   <= hi_next;
    side1 <= side_next;
    cen1  <= center_pixel;
  end

  // Stage 2: rank each valid pixel (ties broken by slot), keep the middle ranks
  always_comb begin
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_PIXELS; j++) begin
        if (j != i && COUNT_BITS'(j) < n1 &&
            (pix1[j] < pix1[i] || (pix1[j] == pix1[i] && j < i))) begin
          rank[i] = rank[i] + COUNT_BITS'(1);
        end
      end
      keep_next[i] = (COUNT_BITS'(i) < n1) && (rank[i] >= COUNT_BITS'(t1)) &&
                     (rank[i] < hi1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    keep2 <= keep_next;
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      pix2[i] <= pix1[i];
    end
    side2 <= side1;
    cen2  <= cen1;
  end

  // Stage 3: sum the kept pixels
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < WINDOW_PIXELS; i++) begin
      if (keep2[i]) begin
        sum_next = sum_next + SUM_BITS'(pix2[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sum3  <= sum_next;
    side3 <= side2;
    cen3  <= cen2;
  end

  // Stage 4: multiply by the reciprocal of the kept count
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    prod4 <= PROD_BITS'(sum3) * PROD_BITS'(RECIP_TAB[side3.kept]);
    pass4 <= side3.pass;
    cen4  <= cen3;
  end

  // Stage 5: take the 12.8 quotient or the centre, saturate to the 8.8 output width
  always_comb begin
    if (pass4) begin
      sel_ext = EXT_BITS'({cen4, {FRAC_BITS{1'b0}}});
    end else begin
      sel_ext = EXT_BITS'(prod4[SHIFT-FRAC_BITS +: QUO_BITS]);
    end
    if (|sel_ext[EXT_BITS-1:OUT_BITS]) begin
      value_next = '1;
    end else begin
      value_next = sel_ext[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    filtered_value <= value_next;
    passed_through <= pass4;
  end

  // Every done pulse comes from an earlier accepted word
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("done without a matching accepted word");

  // A window that is not passed through always keeps at least one pixel
  a_kept_range: assert property (@(posedge clk) disable iff (rst)
    v1 && !side1.pass |-> side1.kept != '0 && side1.kept <= W_CNT)
    else $error("kept count out of range");

  // Rank selection keeps exactly the expected number of pixels
  a_keep_count: assert property (@(posedge clk) disable iff (rst)
    v2 && !side2.pass |-> $countones(keep2) == int'(side2.kept))
    else $error("keep mask does not match kept count");

  // A passed-through centre has no fraction bits unless it saturated
  a_pass_frac: assert property (@(posedge clk) disable iff (rst)
    done && passed_through |->
      filtered_value[FRAC_BITS-1:0] == '0 || filtered_value == '1)
    else $error("pass-through word carries fraction bits");

endmodule
